@@ design/bpc_pkg.sv @@
// shared constants and widths for the block permutation cipher
package bpc_pkg;

  localparam int BYTE_W                 = 8;
  localparam int DIGIT_W                = 4;
  localparam int KEY_DIGIT_COUNT        = 9;
  localparam int KEY_W                  = DIGIT_W * KEY_DIGIT_COUNT;
  localparam int KEY_LEN_W              = 4;
  localparam int DEFAULT_MAX_KEY_DIGITS = 9;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_KEY_DIGITS   = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
  localparam logic [1:0] REG_PAD_CHAR     = 2'd2;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd3;

  localparam logic [KEY_W-1:0]     KEY_DIGITS_RST = KEY_W'(1);
  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = KEY_LEN_W'(1);
  localparam logic [BYTE_W-1:0]    PAD_CHAR_RST   = BYTE_W'(32);

endpackage

@@ design/bpc_ifs.sv @@
// valid/ready stream interfaces for message bytes and permuted bytes
interface bpc_data_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bpc_result_if;
  import bpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ design/block_permutation_cipher.sv @@
// block transposition cipher: collects bytes into blocks, emits them permuted by the key
// a byte that does not close a block is stored, and the block stays ready for the next byte
// a closing byte starts mapping: the shared digit unit reads one key digit a cycle to build
// the permutation map, then each result byte goes through a load and a send state (send holds until ready)
// results leave through a registered output stage; no byte is taken until the block is sent
// rst is synchronous, active high: control, fill count, map flags and config registers return to defaults
module block_permutation_cipher #(
  parameter int MAX_KEY_DIGITS = bpc_pkg::DEFAULT_MAX_KEY_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  bpc_data_if.sink                      data_ch,
  bpc_result_if.source                  result_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bpc_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import bpc_pkg::*;

  // count holds 0..MAX, index addresses 0..MAX-1
  localparam int CNT_W = $clog2(MAX_KEY_DIGITS + 1);
  localparam int IDX_W = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAP  = 4'b0010,
    S_LOAD = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  // configuration registers
  logic [KEY_W-1:0]     key_digits;
  logic [KEY_LEN_W-1:0] key_length;
  logic [BYTE_W-1:0]    pad_char;
  logic                 decrypt_mode;

  // control state
  state_t               state;
  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     step;        // key digit index while mapping, output index while sending
  logic                 last_flag;

  // block storage and permutation map (map_src: source slot of each output slot)
  logic [BYTE_W-1:0]    block_buffer [MAX_KEY_DIGITS];
  logic [IDX_W-1:0]     map_src      [MAX_KEY_DIGITS];
  logic [MAX_KEY_DIGITS-1:0] map_ok;

  logic [CNT_W-1:0]     blk_size;
  logic [CNT_W-1:0]     fill_base;
  logic [CNT_W-1:0]     fill_inc;
  logic                 block_close;
  logic                 in_fire;
  logic                 cfg_write;
  logic [1:0]           reg_sel;

  logic [KEY_W-1:0]     key_shift;
  logic [DIGIT_W-1:0]   digit;
  logic [DIGIT_W-1:0]   digit_m1;
  logic                 digit_ok;
  logic [IDX_W-1:0]     step_idx;
  logic [IDX_W-1:0]     dm1_idx;
  logic [IDX_W-1:0]     map_waddr;
  logic [IDX_W-1:0]     map_wdata;
  logic                 map_wen;
  logic                 map_wok;
  logic                 step_end;

  // ---------------------------------------------------------------
  // APB register file; address bits [4:3] pick the register
  // ---------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_digits   <= KEY_DIGITS_RST;
      key_length   <= KEY_LENGTH_RST;
      pad_char     <= PAD_CHAR_RST;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_KEY_DIGITS:   key_digits   <= pwdata[KEY_W-1:0];
        REG_KEY_LENGTH:   key_length   <= pwdata[KEY_LEN_W-1:0];
        REG_PAD_CHAR:     pad_char     <= pwdata[BYTE_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_DIGITS:   prdata = APB_DATA_W'(key_digits);
      REG_KEY_LENGTH:   prdata = APB_DATA_W'(key_length);
      REG_PAD_CHAR:     prdata = APB_DATA_W'(pad_char);
      REG_DECRYPT_MODE: prdata = APB_DATA_W'(decrypt_mode);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // block size: zero length counts as one, long keys saturate
  // ---------------------------------------------------------------
  always_comb begin
    if (key_length == '0) begin
      blk_size = CNT_W'(1);
    end else if ({1'b0, key_length} > (KEY_LEN_W + 1)'(MAX_KEY_DIGITS)) begin
      blk_size = CNT_W'(MAX_KEY_DIGITS);
    end else begin
      blk_size = CNT_W'(key_length);
    end
  end

  // ---------------------------------------------------------------
  // byte intake: a stale count (key shrunk mid-block) starts a new block
  // ---------------------------------------------------------------
  assign data_ch.ready = (state == S_IDLE);
  assign in_fire       = data_ch.valid && data_ch.ready;
  assign fill_base     = (fill_count >= blk_size) ? '0 : fill_count;
  assign fill_inc      = fill_base + CNT_W'(1);
  assign block_close   = (fill_inc >= blk_size) || data_ch.last_byte;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      block_buffer[fill_base[IDX_W-1:0]] <= data_ch.data_byte;
    end
  end

  // ---------------------------------------------------------------
  // shared digit unit: one key digit per cycle, shift past the key reads zero
  // ---------------------------------------------------------------
  assign step_idx  = step[IDX_W-1:0];
  assign key_shift = key_digits >> {step, 2'b00};
  assign digit     = key_shift[DIGIT_W-1:0];
  assign digit_ok  = (digit != '0) && (digit <= DIGIT_W'(blk_size));
  assign digit_m1  = digit - DIGIT_W'(1);
  assign dm1_idx   = digit_m1[IDX_W-1:0];
  assign step_end  = (step == blk_size - CNT_W'(1));

  // encrypt: out slot j reads slot digit j - 1
  // decrypt: out slot digit j - 1 reads slot j, first match wins
  always_comb begin
    if (decrypt_mode) begin
      map_waddr = dm1_idx;
      map_wdata = step_idx;
      map_wen   = digit_ok && !map_ok[dm1_idx];
      map_wok   = 1'b1;
    end else begin
      map_waddr = step_idx;
      map_wdata = dm1_idx;
      map_wen   = 1'b1;
      map_wok   = digit_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAP && map_wen) begin
      map_src[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_ok <= '0;
    end else if (in_fire && block_close) begin
      map_ok <= '0;
    end else if (state == S_MAP && map_wen) begin
      map_ok[map_waddr] <= map_wok;
    end
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      step       <= '0;
      last_flag  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            fill_count <= fill_inc;
            last_flag  <= data_ch.last_byte;
            step       <= '0;
            if (block_close) begin
              state <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (step_end) begin
            step  <= '0;
            state <= S_LOAD;
          end else begin
            step <= step + CNT_W'(1);
          end
        end
        S_LOAD: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (result_ch.ready) begin
            if (step_end) begin
              fill_count <= '0;
              state      <= S_IDLE;
            end else begin
              step  <= step + CNT_W'(1);
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // output register: unmapped slots and slots past the fill carry the pad
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      if (map_ok[step_idx] && (CNT_W'(map_src[step_idx]) < fill_count)) begin
        result_ch.out_byte <= block_buffer[map_src[step_idx]];
      end else begin
        result_ch.out_byte <= pad_char;
      end
      result_ch.out_last <= last_flag && step_end;
    end
  end

  assign result_ch.valid = (state == S_SEND);

endmodule
